// ----- rtl/rsp_pkg.sv -----
// Shared types, constants and helpers for the RESP stream parser.
`timescale 1ns / 1ps

package rsp_pkg;

   // Array nesting limit and the widths that follow from it
   localparam int MAX_DEPTH = 8;
   localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   // Element counts and bulk lengths are positive signed 32-bit values
   localparam int CNT_W = 31;

   localparam logic [31:0] MAG_CAP = 32'h8000_0000;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

   // Protocol characters
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_STR,
      PH_INT,
      PH_BLEN,
      PH_ACNT,
      PH_BULK,
      PH_SKIP1,
      PH_SKIP2
   } phase_type;

   typedef enum logic [3:0] {
      EV_SIMPLE_BYTE,
      EV_ERROR_BYTE,
      EV_BULK_BYTE,
      EV_SIMPLE_END,
      EV_ERROR_END,
      EV_BULK_END,
      EV_NULL,
      EV_INTEGER,
      EV_ARRAY,
      EV_PROTO_ERR
   } event_type;

   // Position inside a number line
   typedef enum logic [1:0] {
      LP_START,
      LP_DIGITS,
      LP_STOP
   } lpos_type;

   typedef struct packed {
      event_type   ev;
      logic [7:0]  data;
      logic [31:0] number;
      logic [3:0]  depth;
      logic        done;
   } res_type;

   typedef struct packed {
      logic             push;
      logic             finish;
      logic             clear;
      logic [CNT_W-1:0] value;
   } stk_cmd_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic             fin_done;
      logic             full;
   } stk_sts_type;

   typedef struct packed {
      logic        clear;
      logic        feed;
      logic        stop;
      logic        load;
      logic [7:0]  ch;
      logic [31:0] value;
   } num_cmd_type;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] acc;
      logic        neg;
   } num_sts_type;

   function automatic res_type mk_res(event_type ev, logic [7:0] data,
                                      logic [31:0] number, logic [3:0] depth,
                                      logic done);
      res_type r;
      r.ev     = ev;
      r.data   = data;
      r.number = number;
      r.depth  = depth;
      r.done   = done;
      return r;
   endfunction

endpackage

// ----- rtl/resp_stream_parser.sv -----
// Top level of the RESP stream parser: byte register, phase control, result queue.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_in_byte
//   rsp      out        rsp_valid/rsp_stall   rsp_event_res, rsp_data_byte, rsp_number,
//                                             rsp_depth, rsp_message_done
//
// One byte per cycle while req_stall is low: a byte is held in the input register,
// is parsed there and its zero, one or two results enter a two-entry queue.
// A byte that yields two results (lone CR in a string) waits in the input register
// until the queue has room for both; rate is set by the rsp drain.
// Synchronous reset returns the parser to idle with an empty queue.
// rsp_stall backs up the queue, then the input register, then req_stall.
`timescale 1ns / 1ps

module resp_stream_parser import rsp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_event_res,
   output logic [7:0]         rsp_data_byte,
   output logic signed [31:0] rsp_number,
   output logic [3:0]         rsp_depth,
   output logic               rsp_message_done
);

   logic             in_vld_ff;
   logic [7:0]       in_byte_ff;
   phase_type        phase_ff, phase_in;
   logic             pend_ff, pend_in;
   logic             kind_ff, kind_in;
   logic [CNT_W-1:0] brem_ff, brem_in;

   logic [7:0]  c;
   logic        pend_lf;
   logic        is_type;
   logic        step;
   logic [1:0]  n_res;
   logic [1:0]  wr_n;
   logic [1:0]  room;
   logic [3:0]  dep;
   res_type     res0, res1;
   res_type     head;
   stk_cmd_type stk_cmd;
   stk_sts_type stk_sts;
   num_cmd_type num_cmd;
   num_sts_type num_sts;

   assign c       = in_byte_ff;
   assign pend_lf = pend_ff && (c == CH_LF);
   assign is_type = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_COLON) ||
                    (c == CH_DOLLAR) || (c == CH_STAR);
   assign dep     = 4'(stk_sts.level);

   // A held byte is parsed once the queue has room for all its results
   assign step      = in_vld_ff && (n_res <= room);
   assign wr_n      = step ? n_res : 2'd0;
   assign req_stall = in_vld_ff && !step;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (c == CH_PLUS || c == CH_MINUS) begin
               phase_in = PH_STR;
            end else if (c == CH_COLON) begin
               phase_in = PH_INT;
            end else if (c == CH_DOLLAR) begin
               phase_in = PH_BLEN;
            end else if (c == CH_STAR) begin
               phase_in = PH_ACNT;
            end
         end
         PH_STR: begin
            if (pend_lf) begin
               phase_in = PH_IDLE;
            end
         end
         PH_INT, PH_BLEN, PH_ACNT: begin
            if (pend_lf) begin
               if (phase_ff == PH_BLEN && !(num_sts.neg && num_sts.acc != 32'd0)) begin
                  phase_in = (num_sts.value != 32'd0) ? PH_BULK : PH_SKIP1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_BULK: begin
            if (brem_ff == CNT_W'(1)) begin
               phase_in = PH_SKIP1;
            end
         end
         PH_SKIP1: phase_in = PH_SKIP2;
         PH_SKIP2: phase_in = PH_IDLE;
         default:  phase_in = PH_IDLE;
      endcase
   end

   // Results and commands for the held byte
   always_comb begin
      res0        = '0;
      res1        = '0;
      n_res       = 2'd0;
      stk_cmd     = '0;
      num_cmd     = '0;
      num_cmd.ch  = c;
      num_cmd.value = num_sts.value;
      stk_cmd.value = num_sts.value[CNT_W-1:0];
      pend_in     = pend_ff;
      kind_in     = kind_ff;
      brem_in     = brem_ff;
      case (phase_ff)
         PH_IDLE: begin
            pend_in       = 1'b0;
            num_cmd.clear = 1'b1;
            if (c == CH_PLUS) begin
               kind_in = 1'b0;
            end else if (c == CH_MINUS) begin
               kind_in = 1'b1;
            end else if (!is_type) begin
               res0          = mk_res(EV_PROTO_ERR, 8'd0, 32'd0, 4'd0, 1'b1);
               n_res         = 2'd1;
               stk_cmd.clear = 1'b1;
            end
         end
         PH_STR: begin
            if (pend_lf) begin
               pend_in        = 1'b0;
               res0           = mk_res(kind_ff ? EV_ERROR_END : EV_SIMPLE_END, 8'd0,
                                       32'd0, dep, stk_sts.fin_done);
               n_res          = 2'd1;
               stk_cmd.finish = 1'b1;
            end else begin
               pend_in = (c == CH_CR);
               // a lone CR goes out ahead of the byte that follows it
               if (pend_ff) begin
                  res0  = mk_res(kind_ff ? EV_ERROR_BYTE : EV_SIMPLE_BYTE, CH_CR,
                                 32'd0, dep, 1'b0);
                  res1  = mk_res(kind_ff ? EV_ERROR_BYTE : EV_SIMPLE_BYTE, c,
                                 32'd0, dep, 1'b0);
                  n_res = (c == CH_CR) ? 2'd1 : 2'd2;
               end else if (c != CH_CR) begin
                  res0  = mk_res(kind_ff ? EV_ERROR_BYTE : EV_SIMPLE_BYTE, c,
                                 32'd0, dep, 1'b0);
                  n_res = 2'd1;
               end
            end
         end
         PH_INT, PH_BLEN, PH_ACNT: begin
            if (!pend_lf) begin
               pend_in      = (c == CH_CR);
               num_cmd.stop = pend_ff;
               num_cmd.feed = !pend_ff && (c != CH_CR);
            end else begin
               pend_in = 1'b0;
               if (phase_ff == PH_INT) begin
                  res0           = mk_res(EV_INTEGER, 8'd0, num_sts.value, dep,
                                          stk_sts.fin_done);
                  n_res          = 2'd1;
                  stk_cmd.finish = 1'b1;
               end else if (num_sts.neg && num_sts.acc != 32'd0) begin
                  res0           = mk_res(EV_NULL, 8'd0, 32'd0, dep, stk_sts.fin_done);
                  n_res          = 2'd1;
                  stk_cmd.finish = 1'b1;
               end else if (phase_ff == PH_BLEN) begin
                  num_cmd.load = 1'b1;
                  brem_in      = num_sts.value[CNT_W-1:0];
               end else if (num_sts.value == 32'd0) begin
                  res0           = mk_res(EV_ARRAY, 8'd0, 32'd0, dep, stk_sts.fin_done);
                  n_res          = 2'd1;
                  stk_cmd.finish = 1'b1;
               end else if (stk_sts.full) begin
                  res0          = mk_res(EV_PROTO_ERR, 8'd0, 32'd0, 4'd0, 1'b1);
                  n_res         = 2'd1;
                  stk_cmd.clear = 1'b1;
               end else begin
                  res0         = mk_res(EV_ARRAY, 8'd0, num_sts.value, dep, 1'b0);
                  n_res        = 2'd1;
                  stk_cmd.push = 1'b1;
               end
            end
         end
         PH_BULK: begin
            res0    = mk_res(EV_BULK_BYTE, c, 32'd0, dep, 1'b0);
            n_res   = 2'd1;
            brem_in = brem_ff - CNT_W'(1);
         end
         PH_SKIP1: begin
            n_res = 2'd0;
         end
         PH_SKIP2: begin
            res0           = mk_res(EV_BULK_END, 8'd0, num_sts.acc, dep,
                                    stk_sts.fin_done);
            n_res          = 2'd1;
            stk_cmd.finish = 1'b1;
         end
         default: begin
            n_res = 2'd0;
         end
      endcase
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pend_ff  <= 1'b0;
         kind_ff  <= 1'b0;
         brem_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         kind_ff  <= kind_in;
         brem_ff  <= brem_in;
      end
   end

   rsp_numln u_numln (
      .clock (clock),
      .reset (reset),
      .en    (step),
      .cmd   (num_cmd),
      .sts   (num_sts)
   );

   rsp_stk u_stk (
      .clock (clock),
      .reset (reset),
      .en    (step),
      .cmd   (stk_cmd),
      .sts   (stk_sts)
   );

   rsp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .wr_n      (wr_n),
      .wr0       (res0),
      .wr1       (res1),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_head  (head),
      .room      (room)
   );

   assign rsp_event_res    = head.ev;
   assign rsp_data_byte    = head.data;
   assign rsp_number       = $signed(head.number);
   assign rsp_depth        = head.depth;
   assign rsp_message_done = head.done;

`ifndef ASSERT_OFF
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_PROTO_ERR |-> rsp_depth == 4'd0 && rsp_message_done)
      else $error("protocol error transaction with depth or open message");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      stk_sts.level <= LVL_W'(MAX_DEPTH))
      else $error("nesting level beyond limit");

   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      step && n_res != 2'd0 && res0.ev == EV_PROTO_ERR |=>
         phase_ff == PH_IDLE && stk_sts.level == '0)
      else $error("parser not idle after protocol error");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> !req_stall)
      else $error("input stalled with empty byte register");
`endif

endmodule

// ----- rtl/rsp_numln.sv -----
// Decimal line accumulator: sign, saturating magnitude and signed value.
`timescale 1ns / 1ps

module rsp_numln import rsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  num_cmd_type cmd,
   output num_sts_type sts
);

   logic        neg_ff, neg_in;
   logic [31:0] acc_ff, acc_in;
   lpos_type    pos_ff, pos_in;

   logic [35:0] mag_x10;
   logic [35:0] mag_new;
   logic        is_sign;
   logic        is_digit;

   // acc * 10 + digit, as two shifts and adds
   assign mag_x10  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0};
   assign mag_new  = mag_x10 + {32'd0, 4'(cmd.ch - CH_ZERO)};
   assign is_sign  = (cmd.ch == CH_MINUS) || (cmd.ch == CH_PLUS);
   assign is_digit = (cmd.ch >= CH_ZERO) && (cmd.ch <= CH_NINE);

   // Next line state
   always_comb begin
      neg_in = neg_ff;
      acc_in = acc_ff;
      pos_in = pos_ff;
      if (cmd.clear) begin
         neg_in = 1'b0;
         acc_in = '0;
         pos_in = LP_START;
      end else if (cmd.load) begin
         acc_in = cmd.value;
      end else if (cmd.stop) begin
         pos_in = LP_STOP;
      end else if (cmd.feed) begin
         if (pos_ff == LP_START && is_sign) begin
            neg_in = (cmd.ch == CH_MINUS);
            pos_in = LP_DIGITS;
         end else if (pos_ff != LP_STOP && is_digit) begin
            acc_in = (mag_new > {4'd0, MAG_CAP}) ? MAG_CAP : mag_new[31:0];
            pos_in = LP_DIGITS;
         end else begin
            pos_in = LP_STOP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff <= 1'b0;
         acc_ff <= '0;
         pos_ff <= LP_START;
      end else if (en) begin
         neg_ff <= neg_in;
         acc_ff <= acc_in;
         pos_ff <= pos_in;
      end
   end

   // Signed value, clamped on the positive side
   always_comb begin
      sts.acc = acc_ff;
      sts.neg = neg_ff;
      if (neg_ff) begin
         sts.value = 32'd0 - acc_ff;
      end else begin
         sts.value = (acc_ff > POS_MAX) ? POS_MAX : acc_ff;
      end
   end

endmodule

// ----- rtl/rsp_stk.sv -----
// Stack of remaining array element counts with the element-finish pop.
`timescale 1ns / 1ps

module rsp_stk import rsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  stk_cmd_type cmd,
   output stk_sts_type sts
);

   logic [CNT_W-1:0] count_ff [MAX_DEPTH];
   logic [LVL_W-1:0] level_ff, level_in;

   logic             top_fnd;
   logic [IDX_W-1:0] top_idx;

   // Every live entry holds at least one; entries at one pop together with
   // the finished child, so the new top is the highest entry above one.
   always_comb begin
      top_fnd = 1'b0;
      top_idx = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if (LVL_W'(i) < level_ff && count_ff[i] != CNT_W'(1)) begin
            top_fnd = 1'b1;
            top_idx = IDX_W'(i);
         end
      end
   end

   assign sts.level    = level_ff;
   assign sts.fin_done = !top_fnd;
   assign sts.full     = (level_ff >= LVL_W'(MAX_DEPTH));

   // Next level
   always_comb begin
      level_in = level_ff;
      if (cmd.clear) begin
         level_in = '0;
      end else if (cmd.push) begin
         level_in = level_ff + LVL_W'(1);
      end else if (cmd.finish) begin
         level_in = top_fnd ? (LVL_W'(top_idx) + LVL_W'(1)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (en) begin
         level_ff <= level_in;
      end
   end

   // Each entry loads on push or counts down when it is the new top
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if (en && !cmd.clear) begin
            if (cmd.push && level_ff == LVL_W'(i)) begin
               count_ff[i] <= cmd.value;
            end else if (cmd.finish && top_fnd && top_idx == IDX_W'(i)) begin
               count_ff[i] <= count_ff[i] - CNT_W'(1);
            end
         end
      end
   end

endmodule

// ----- rtl/rsp_outq.sv -----
// Two-entry result queue in front of the result channel.
`timescale 1ns / 1ps

module rsp_outq import rsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] wr_n,
   input  res_type    wr0,
   input  res_type    wr1,
   input  logic       out_stall,
   output logic       out_valid,
   output res_type    out_head,
   output logic [1:0] room
);

   logic [1:0] cnt_ff, cnt_in;
   res_type    q_ff [2];
   res_type    q0_in, q1_in;
   logic       pop;
   logic [1:0] rem;

   assign out_valid = (cnt_ff != 2'd0);
   assign out_head  = q_ff[0];
   assign pop       = out_valid && !out_stall;
   assign rem       = cnt_ff - {1'b0, pop};
   assign room      = 2'd2 - rem;

   // Shift out the head, then append new results behind what remains
   always_comb begin
      cnt_in = rem + wr_n;
      q0_in  = pop ? q_ff[1] : q_ff[0];
      q1_in  = q_ff[1];
      if (rem == 2'd0) begin
         q0_in = wr0;
         q1_in = wr1;
      end else if (rem == 2'd1) begin
         q1_in = wr0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q0_in;
      q_ff[1] <= q1_in;
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");
`endif

endmodule
